// File: hdl/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMP(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NXT(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

// File: hdl/y86bsd_pkg.sv
package y86bsd_pkg;

	localparam int INST_ADDR_W = 32;
	localparam int IMM_W       = 32;
	localparam int MN_W        = 5;
	localparam int NIB_W       = 4;
	localparam int BYTE_W      = 8;
	localparam int PHASE_W     = 3;
	localparam int ST_W        = 2;
	localparam int TDATA_W     = 80;

	// instruction codes (upper nibble of the first byte)
	localparam logic [3:0] IC_NOP    = 4'd0;
	localparam logic [3:0] IC_HALT   = 4'd1;
	localparam logic [3:0] IC_RRMOVL = 4'd2;
	localparam logic [3:0] IC_IRMOVL = 4'd3;
	localparam logic [3:0] IC_RMMOVL = 4'd4;
	localparam logic [3:0] IC_MRMOVL = 4'd5;
	localparam logic [3:0] IC_OPL    = 4'd6;
	localparam logic [3:0] IC_JXX    = 4'd7;
	localparam logic [3:0] IC_CALL   = 4'd8;
	localparam logic [3:0] IC_RET    = 4'd9;
	localparam logic [3:0] IC_PUSHL  = 4'd10;
	localparam logic [3:0] IC_POPL   = 4'd11;
	localparam logic [3:0] IC_READX  = 4'd12;
	localparam logic [3:0] IC_WRITEX = 4'd13;
	localparam logic [3:0] IC_MOVSBL = 4'd14;
	localparam logic [3:0] IC_BAD    = 4'd15;

	localparam logic [3:0] FN_OPL_MAX = 4'd5;
	localparam logic [3:0] FN_JXX_MAX = 4'd6;
	localparam logic [3:0] FN_BYTE    = 4'd0;

	// mnemonic codes
	localparam logic [4:0] MN_NOP    = 5'd0;
	localparam logic [4:0] MN_HALT   = 5'd1;
	localparam logic [4:0] MN_RRMOVL = 5'd2;
	localparam logic [4:0] MN_IRMOVL = 5'd3;
	localparam logic [4:0] MN_RMMOVL = 5'd4;
	localparam logic [4:0] MN_MRMOVL = 5'd5;
	localparam logic [4:0] MN_ADDL   = 5'd6;
	localparam logic [4:0] MN_JMP    = 5'd12;
	localparam logic [4:0] MN_CALL   = 5'd19;
	localparam logic [4:0] MN_RET    = 5'd20;
	localparam logic [4:0] MN_PUSHL  = 5'd21;
	localparam logic [4:0] MN_POPL   = 5'd22;
	localparam logic [4:0] MN_READB  = 5'd23;
	localparam logic [4:0] MN_READL  = 5'd24;
	localparam logic [4:0] MN_WRITEB = 5'd25;
	localparam logic [4:0] MN_WRITEL = 5'd26;
	localparam logic [4:0] MN_MOVSBL = 5'd27;
	localparam logic [4:0] MN_LAST   = MN_MOVSBL;

	// instruction lengths in bytes
	localparam logic [2:0] LEN_1 = 3'd1;
	localparam logic [2:0] LEN_2 = 3'd2;
	localparam logic [2:0] LEN_5 = 3'd5;
	localparam logic [2:0] LEN_6 = 3'd6;

	// result status codes
	localparam logic [1:0] ST_DECODED = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_TRUNC   = 2'd2;

	typedef struct packed {
		logic       valid;
		logic       has_regs;
		logic [2:0] length;
		logic [4:0] mnemonic;
	} inst_info_t;

endpackage

// File: hdl/y86bsd_decode.sv
module y86bsd_decode (
	input  logic [3:0]             icode,
	input  logic [3:0]             ifun,
	output y86bsd_pkg::inst_info_t info
);
	import y86bsd_pkg::*;

	always_comb begin
		info.valid    = 1'b1;
		info.has_regs = 1'b0;
		info.length   = LEN_1;
		info.mnemonic = MN_NOP;
		case (icode)
			IC_NOP: begin
				info.mnemonic = MN_NOP;
			end
			IC_HALT: begin
				info.mnemonic = MN_HALT;
			end
			IC_RRMOVL: begin
				info.has_regs = 1'b1;
				info.length   = LEN_2;
				info.mnemonic = MN_RRMOVL;
			end
			IC_IRMOVL: begin
				info.has_regs = 1'b1;
				info.length   = LEN_6;
				info.mnemonic = MN_IRMOVL;
			end
			IC_RMMOVL: begin
				info.has_regs = 1'b1;
				info.length   = LEN_6;
				info.mnemonic = MN_RMMOVL;
			end
			IC_MRMOVL: begin
				info.has_regs = 1'b1;
				info.length   = LEN_6;
				info.mnemonic = MN_MRMOVL;
			end
			IC_OPL: begin
				info.has_regs = 1'b1;
				info.length   = LEN_2;
				info.valid    = (ifun <= FN_OPL_MAX);
				info.mnemonic = MN_ADDL + (info.valid ? MN_W'(ifun) : MN_NOP);
			end
			IC_JXX: begin
				info.length   = LEN_5;
				info.valid    = (ifun <= FN_JXX_MAX);
				info.mnemonic = MN_JMP + (info.valid ? MN_W'(ifun) : MN_NOP);
			end
			IC_CALL: begin
				info.length   = LEN_5;
				info.mnemonic = MN_CALL;
			end
			IC_RET: begin
				info.mnemonic = MN_RET;
			end
			IC_PUSHL: begin
				info.has_regs = 1'b1;
				info.length   = LEN_2;
				info.mnemonic = MN_PUSHL;
			end
			IC_POPL: begin
				info.has_regs = 1'b1;
				info.length   = LEN_2;
				info.mnemonic = MN_POPL;
			end
			IC_READX: begin
				info.has_regs = 1'b1;
				info.length   = LEN_6;
				info.mnemonic = (ifun == FN_BYTE) ? MN_READB : MN_READL;
			end
			IC_WRITEX: begin
				info.has_regs = 1'b1;
				info.length   = LEN_6;
				info.mnemonic = (ifun == FN_BYTE) ? MN_WRITEB : MN_WRITEL;
			end
			IC_MOVSBL: begin
				info.has_regs = 1'b1;
				info.length   = LEN_6;
				info.mnemonic = MN_MOVSBL;
			end
			default: begin
				// bad instruction code
				info.valid    = 1'b0;
				info.mnemonic = MN_NOP;
			end
		endcase
	end

endmodule

// File: hdl/y86_byte_stream_decoder.sv
// Flow: a word is captured in the input stage and decoded, and the result register that
// drives m_tvalid loads the result when the word completes or ends an instruction.
// Throughput: one byte word per cycle; the single decode pass between the input stage
// and the result register sets it, and a stalled result register holds the input stage.
// Reset (arst_n low, asynchronous): empty both stages, clear the stop flag, load start
// address 0 and expect an opcode byte. Only reset releases a stopped decoder.
module y86_byte_stream_decoder #(
	parameter int ADDR_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// input byte stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] code_byte
	input  logic        s_tlast,   // last_byte
	// decoded instruction stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // [31:0] inst_address, [36:32] mnemonic,
	                               // [40:37] reg_a, [44:41] reg_b,
	                               // [76:45] immediate, [79:77] zero
	output logic [1:0]  m_tuser,   // [1:0] status
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import y86bsd_pkg::*;

	// configuration register and address state
	logic [31:0]           start_addr_q;
	logic [ADDR_WIDTH-1:0] byte_addr_q;
	logic [ADDR_WIDTH-1:0] inst_start_q;

	// partial instruction state
	logic [PHASE_W-1:0] phase_q;
	logic [NIB_W-1:0]   icode_q;
	logic [NIB_W-1:0]   ifun_q;
	logic [BYTE_W-1:0]  regs_q;
	logic [IMM_W-1:0]   imm_q;
	logic               stopped_q;

	// input stage
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;

	// result register
	logic                   valid_s2;
	logic [INST_ADDR_W-1:0] addr_s2;
	logic [MN_W-1:0]        mn_s2;
	logic [BYTE_W-1:0]      regs_s2;
	logic [IMM_W-1:0]       imm_s2;
	logic [ST_W-1:0]        status_s2;

	// decode pass
	logic                  advance;
	logic                  cfg_wr;
	logic                  first_byte;
	logic [NIB_W-1:0]      cur_icode;
	logic [NIB_W-1:0]      cur_ifun;
	inst_info_t            info;
	logic [PHASE_W-1:0]    phase_inc;
	logic [PHASE_W-1:0]    lane_sel;
	logic [BYTE_W-1:0]     regs_nxt;
	logic [IMM_W-1:0]      imm_nxt;
	logic [ADDR_WIDTH-1:0] cur_addr;
	logic                  emit;
	logic                  done_inst;
	logic                  bad_code;
	logic [PHASE_W-1:0]    phase_nxt;
	logic                  stop_nxt;
	logic [MN_W-1:0]       res_mn;
	logic [BYTE_W-1:0]     res_regs;
	logic [IMM_W-1:0]      res_imm;
	logic [ST_W-1:0]       res_status;

	// Register 0 (start_address) lies at byte address 0; paddr[2] selects beyond it.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready & ~paddr[2];
	assign prdata = paddr[2] ? '0 : start_addr_q;

	// The input stage moves on only when the result register is free or being drained.
	assign advance  = valid_s1 & (~valid_s2 | m_tready);
	assign s_tready = ~valid_s1 | advance;

	// On the first byte of an instruction the opcode comes straight from the word.
	assign first_byte = (phase_q == '0);
	assign cur_icode  = first_byte ? byte_s1[7:4] : icode_q;
	assign cur_ifun   = first_byte ? byte_s1[3:0] : ifun_q;

	y86bsd_decode u_decode (
		.icode (cur_icode),
		.ifun  (cur_ifun),
		.info  (info)
	);

	always_comb begin
		phase_inc = phase_q + 3'd1;
		// immediate byte lane: count bytes after the opcode and the register byte
		lane_sel  = phase_q - (info.has_regs ? 3'd2 : 3'd1);
		cur_addr  = first_byte ? byte_addr_q : inst_start_q;

		if (first_byte) begin
			regs_nxt = '0;
			imm_nxt  = '0;
		end else if (info.has_regs && phase_q == 3'd1) begin
			regs_nxt = byte_s1;
			imm_nxt  = imm_q;
		end else begin
			regs_nxt = regs_q;
			imm_nxt  = imm_q | (IMM_W'(byte_s1) << {lane_sel[1:0], 3'b000});
		end

		bad_code   = first_byte & ~info.valid;
		done_inst  = (phase_inc >= info.length);
		emit       = 1'b0;
		phase_nxt  = phase_q;
		stop_nxt   = stopped_q;
		res_mn     = info.mnemonic;
		res_regs   = '0;
		res_imm    = '0;
		res_status = ST_DECODED;

		if (!stopped_q) begin
			if (bad_code) begin
				// invalid opcode wins over an end-of-memory mark
				emit       = 1'b1;
				stop_nxt   = 1'b1;
				res_mn     = MN_NOP;
				res_status = ST_INVALID;
			end else if (done_inst) begin
				emit      = 1'b1;
				phase_nxt = '0;
				stop_nxt  = last_s1;
				res_regs  = regs_nxt;
				res_imm   = imm_nxt;
			end else if (last_s1) begin
				// memory ends partway through an instruction
				emit       = 1'b1;
				phase_nxt  = '0;
				stop_nxt   = 1'b1;
				res_status = ST_TRUNC;
			end else begin
				phase_nxt = phase_inc;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			phase_q      <= '0;
			stopped_q    <= 1'b0;
			start_addr_q <= '0;
			byte_addr_q  <= '0;
			inst_start_q <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			// hold a waiting result, drop it once taken, load a fresh one on emit
			valid_s2 <= (valid_s2 & ~m_tready) | (advance & emit & ~cfg_wr);
			if (cfg_wr) begin
				// restart numbering; the stop flag stays as it is
				start_addr_q <= pwdata;
				byte_addr_q  <= pwdata[ADDR_WIDTH-1:0];
				inst_start_q <= pwdata[ADDR_WIDTH-1:0];
				phase_q      <= '0;
			end else if (advance && !stopped_q) begin
				phase_q     <= phase_nxt;
				stopped_q   <= stop_nxt;
				byte_addr_q <= byte_addr_q + 1'b1;
				if (first_byte) begin
					inst_start_q <= byte_addr_q;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
		if (advance && !stopped_q) begin
			icode_q <= cur_icode;
			ifun_q  <= cur_ifun;
			regs_q  <= regs_nxt;
			imm_q   <= imm_nxt;
		end
		if (advance && emit) begin
			addr_s2   <= INST_ADDR_W'(cur_addr);
			mn_s2     <= res_mn;
			regs_s2   <= res_regs;
			imm_s2    <= res_imm;
			status_s2 <= res_status;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'b000, imm_s2, regs_s2[3:0], regs_s2[7:4], mn_s2, addr_s2};
	assign m_tuser  = status_s2;

endmodule

// File: hdl/y86bsd_checker.sv
`include "assert_macros.svh"

module y86bsd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [79:0] m_tdata,
	input logic [1:0]  m_tuser
);
	import y86bsd_pkg::*;

	// status is one of the three defined codes
	`ASSERT_IMP(a_status_code, clk, arst_n, m_tvalid, m_tuser <= ST_TRUNC)

	// mnemonic stays within the defined range
	`ASSERT_IMP(a_mn_range, clk, arst_n, m_tvalid, m_tdata[36:32] <= MN_LAST)

	// an invalid instruction carries no mnemonic, registers or immediate
	`ASSERT_IMP(a_invalid_empty, clk, arst_n, m_tvalid && m_tuser == ST_INVALID, m_tdata[76:32] == '0)

	// a truncated instruction carries no registers or immediate
	`ASSERT_IMP(a_trunc_empty, clk, arst_n, m_tvalid && m_tuser == ST_TRUNC, m_tdata[76:37] == '0)

	// a stalled word holds
	`ASSERT_NXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind y86_byte_stream_decoder y86bsd_checker u_y86bsd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
